// ----- src/assert_macros.svh -----
// Assertion helpers used by the checker file knfs_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define ASSERT_STD(label, prop, msg) \
  `ASSERT_AT(label, clk_i, rst_ni, prop, msg)

`endif

// ----- src/knfs_pkg.sv -----
`timescale 1ns / 1ps

package knfs_pkg;

  // Number of kept slots.
  localparam int SLOTS   = 16;
  localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(SLOTS + 1);

  localparam int FEAT_W = 16;
  localparam int POS_W  = 32;
  localparam int SPC_W  = 24;
  localparam int DIST_W = 34;
  localparam int SQ_W   = 32;
  localparam int K_W    = 5;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_ADDR_W = 2;

  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 144;

  localparam logic [K_W-1:0] K_RESET = 5'd8;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_QUERY_PATTERN  = 2'd0,
    REG_QUERY_SLOPE    = 2'd1,
    REG_QUERY_RESIDUAL = 2'd2,
    REG_K_COUNT        = 2'd3
  } cfg_reg_e;

  // One kept record; packed so that the lowest field is the x coordinate.
  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [SPC_W-1:0]  min_spacing;
    logic [FEAT_W-1:0] residual;
    logic [POS_W-1:0]  pos_y;
    logic [POS_W-1:0]  pos_x;
  } slot_t;

  // Magnitude of the difference of two signed Q8.8 values; always fits 16 bits.
  function automatic logic [FEAT_W-1:0] abs_diff(input logic [FEAT_W-1:0] a,
                                                 input logic [FEAT_W-1:0] b);
    logic [FEAT_W:0] diff;
    logic [FEAT_W:0] mag;
    diff = {a[FEAT_W-1], a} - {b[FEAT_W-1], b};
    mag  = diff[FEAT_W] ? (~diff + 1'b1) : diff;
    return mag[FEAT_W-1:0];
  endfunction

endpackage

// ----- src/knfs_dist.sv -----
`timescale 1ns / 1ps

module knfs_dist import knfs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [FEAT_W-1:0] rec_pattern_i,
  input  logic [FEAT_W-1:0] rec_slope_i,
  input  logic [FEAT_W-1:0] rec_residual_i,
  input  logic [FEAT_W-1:0] qry_pattern_i,
  input  logic [FEAT_W-1:0] qry_slope_i,
  input  logic [FEAT_W-1:0] qry_residual_i,
  output logic              done_o,
  output logic [DIST_W-1:0] dist_o
);

  // Steps 0..2 square one feature difference each; steps 1..3 accumulate.
  localparam logic [1:0] LAST_STEP = 2'd3;

  logic              busy_q;
  logic [1:0]        step_q;
  logic              done_q;
  logic [SQ_W-1:0]   prod_q;
  logic [DIST_W-1:0] acc_q;
  logic [FEAT_W-1:0] mag;

  always_comb begin
    case (step_q)
      2'd0:    mag = abs_diff(rec_pattern_i, qry_pattern_i);
      2'd1:    mag = abs_diff(rec_slope_i, qry_slope_i);
      default: mag = abs_diff(rec_residual_i, qry_residual_i);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 2'd1;
        if (step_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
    end else if (busy_q) begin
      if (step_q != LAST_STEP) begin
        prod_q <= SQ_W'(mag) * SQ_W'(mag);
      end
      if (step_q != 2'd0) begin
        acc_q <= acc_q + DIST_W'(prod_q);
      end
    end
  end

  assign done_o = done_q;
  assign dist_o = acc_q;

endmodule

// ----- src/knfs_slot_ram.sv -----
`timescale 1ns / 1ps

module knfs_slot_ram import knfs_pkg::*; (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [SLOT_AW-1:0] waddr_i,
  input  slot_t              wdata_i,
  input  logic               re_i,
  input  logic [SLOT_AW-1:0] raddr_i,
  output slot_t              rdata_o
);

  slot_t mem [SLOTS];
  slot_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/k_nearest_feature_select_core.sv -----
`timescale 1ns / 1ps
// A record goes through the distance unit and, while the kept set is filling, straight
// to the slot write; once the set is full, a scan of all kept entries comes in between.
// A new record is taken only in idle; each result of a set is read from a slot, then loaded.
// Reset: asynchronous, active low; clears the sequencer, the fill count, the output
// valid and the query and k registers (k to 8). Slot storage is not cleared.

module k_nearest_feature_select_core import knfs_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,

  // Configuration write port.
  input  logic                   cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,

  // Records in. tdata from bit 0 up: point_pattern, mean_slope, residual,
  // pos_x, pos_y, min_spacing. tlast carries end_of_set.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tlast,

  // Kept records out. tdata from bit 0 up: out_x, out_y, out_residual,
  // out_min_spacing, out_distance, then zero fill. tlast carries last_of_run.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast
);

  // The sequencer walks each record through the shared distance unit, then
  // either appends it to the kept set or scans the slot memory one entry per
  // cycle for the farthest kept entry, which a nearer record replaces. On end
  // of set it reads the slots back in order into the output register.
  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_DIST     = 7'b0000010,
    ST_SCAN     = 7'b0000100,
    ST_SCAN_END = 7'b0001000,
    ST_UPDATE   = 7'b0010000,
    ST_EMIT_RD  = 7'b0100000,
    ST_EMIT_LD  = 7'b1000000
  } state_e;

  typedef struct packed {
    logic [FEAT_W-1:0] pattern;
    logic [FEAT_W-1:0] slope;
    logic [FEAT_W-1:0] residual;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [SPC_W-1:0]  min_spacing;
    logic              last;
  } rec_t;

  state_e state_q, state_d;

  logic [FEAT_W-1:0] qry_pattern_q;
  logic [FEAT_W-1:0] qry_slope_q;
  logic [FEAT_W-1:0] qry_residual_q;
  logic [K_W-1:0]    k_count_q;
  logic [CNT_W-1:0]  eff_k;

  rec_t              rec_q;
  logic              in_accept;

  logic              dist_done;
  logic [DIST_W-1:0] rec_dist;

  logic [CNT_W-1:0]   fill_q;
  logic               fill_mode_q;
  logic [CNT_W-1:0]   scan_q;
  logic               cmp_vld_q;
  logic [SLOT_AW-1:0] rd_idx_q;
  logic [DIST_W-1:0]  max_q;
  logic [SLOT_AW-1:0] best_q;
  logic [CNT_W-1:0]   emit_q;

  logic               ram_we;
  logic [SLOT_AW-1:0] ram_waddr;
  slot_t              ram_wdata;
  logic               ram_re;
  logic [SLOT_AW-1:0] ram_raddr;
  slot_t              ram_rdata;

  slot_t              out_q;
  logic               out_last_q;
  logic               out_valid_q;
  logic               out_load;
  logic               emit_last;

  // Configuration registers. Writes must happen only while idle; the block does not check.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qry_pattern_q  <= '0;
      qry_slope_q    <= '0;
      qry_residual_q <= '0;
      k_count_q      <= K_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_QUERY_PATTERN:  qry_pattern_q  <= cfg_wdata_i;
        REG_QUERY_SLOPE:    qry_slope_q    <= cfg_wdata_i;
        REG_QUERY_RESIDUAL: qry_residual_q <= cfg_wdata_i;
        REG_K_COUNT:        k_count_q      <= cfg_wdata_i[K_W-1:0];
        default:            ;
      endcase
    end
  end

  // A k of zero keeps one entry, and a k above the slot count keeps them all.
  always_comb begin
    if (k_count_q == '0) begin
      eff_k = CNT_W'(1);
    end else if (int'(k_count_q) > SLOTS) begin
      eff_k = CNT_W'(SLOTS);
    end else begin
      eff_k = CNT_W'(k_count_q);
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      rec_q.pattern     <= s_axis_tdata[15:0];
      rec_q.slope       <= s_axis_tdata[31:16];
      rec_q.residual    <= s_axis_tdata[47:32];
      rec_q.pos_x       <= s_axis_tdata[79:48];
      rec_q.pos_y       <= s_axis_tdata[111:80];
      rec_q.min_spacing <= s_axis_tdata[135:112];
      rec_q.last        <= s_axis_tlast;
    end
  end

  // Shared squaring unit: one feature difference per cycle.
  knfs_dist u_dist (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (in_accept),
    .rec_pattern_i  (rec_q.pattern),
    .rec_slope_i    (rec_q.slope),
    .rec_residual_i (rec_q.residual),
    .qry_pattern_i  (qry_pattern_q),
    .qry_slope_i    (qry_slope_q),
    .qry_residual_i (qry_residual_q),
    .done_o         (dist_done),
    .dist_o         (rec_dist)
  );

  // Slot storage. Only entries below the fill count are ever read.
  assign ram_wdata.distance    = rec_dist;
  assign ram_wdata.min_spacing = rec_q.min_spacing;
  assign ram_wdata.residual    = rec_q.residual;
  assign ram_wdata.pos_y       = rec_q.pos_y;
  assign ram_wdata.pos_x       = rec_q.pos_x;

  assign ram_we    = (state_q == ST_UPDATE) && (fill_mode_q || (max_q > rec_dist));
  assign ram_waddr = fill_mode_q ? fill_q[SLOT_AW-1:0] : best_q;
  assign ram_re    = (state_q == ST_SCAN) || (state_q == ST_EMIT_RD);
  assign ram_raddr = (state_q == ST_SCAN) ? scan_q[SLOT_AW-1:0] : emit_q[SLOT_AW-1:0];

  knfs_slot_ram u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // The output register is free when empty or being taken this cycle, so a
  // new record can be accepted while the final result of a set still waits.
  assign out_load  = (state_q == ST_EMIT_LD) && (!out_valid_q || m_axis_tready);
  assign emit_last = (emit_q == fill_q - CNT_W'(1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_DIST;
        end
      end
      ST_DIST: begin
        if (dist_done) begin
          state_d = ((fill_q < eff_k) && (int'(fill_q) < SLOTS)) ? ST_UPDATE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_q == fill_q - CNT_W'(1)) begin
          state_d = ST_SCAN_END;
        end
      end
      ST_SCAN_END: state_d = ST_UPDATE;
      ST_UPDATE:   state_d = rec_q.last ? ST_EMIT_RD : ST_IDLE;
      ST_EMIT_RD:  state_d = ST_EMIT_LD;
      ST_EMIT_LD: begin
        if (out_load) begin
          state_d = emit_last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      fill_mode_q <= 1'b0;
      scan_q      <= '0;
      cmp_vld_q   <= 1'b0;
      emit_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= (state_q == ST_SCAN);

      if ((state_q == ST_DIST) && dist_done) begin
        fill_mode_q <= (fill_q < eff_k) && (int'(fill_q) < SLOTS);
        scan_q      <= '0;
      end
      if (state_q == ST_SCAN) begin
        scan_q <= scan_q + CNT_W'(1);
      end
      if ((state_q == ST_UPDATE) && fill_mode_q) begin
        fill_q <= fill_q + CNT_W'(1);
      end
      if (state_q == ST_UPDATE) begin
        emit_q <= '0;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
        if (emit_last) begin
          fill_q <= '0;
        end else begin
          emit_q <= emit_q + CNT_W'(1);
        end
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Running maximum over the scanned slots; a later slot wins only when it
  // is strictly farther, so ties keep the earliest slot.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_SCAN) begin
      rd_idx_q <= scan_q[SLOT_AW-1:0];
    end
    if (cmp_vld_q && ((rd_idx_q == '0) || (ram_rdata.distance > max_q))) begin
      max_q  <= ram_rdata.distance;
      best_q <= rd_idx_q;
    end
    if (out_load) begin
      out_q      <= ram_rdata;
      out_last_q <= emit_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - $bits(slot_t)){1'b0}}, out_q};
  assign m_axis_tlast  = out_last_q;

endmodule

// ----- src/knfs_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module knfs_checker import knfs_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   s_axis_tlast,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tlast
);

  // The block works on one record at a time.
  `ASSERT_STD(a_busy_after_accept, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "input accepted while busy")

  // A record that does not close a set never starts output on its own.
  `ASSERT_STD(a_no_spurious_out, (s_axis_tvalid && s_axis_tready && !s_axis_tlast && !m_axis_tvalid) |=> !m_axis_tvalid, "output without end of set")

  `ASSERT_STD(a_out_valid_hold, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid, "output valid dropped")

  `ASSERT_STD(a_out_data_hold, (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tlast)), "output changed under stall")

endmodule

bind k_nearest_feature_select_core knfs_checker u_knfs_checker (.*);

// ----- verif/knfs_kept_set_checker.sv -----
`timescale 1ns / 1ps

module knfs_kept_set_checker import knfs_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  // From bit 0 up: point_pattern, mean_slope, residual, pos_x, pos_y, min_spacing.
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tlast,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // From bit 0 up: out_x, out_y, out_residual, out_min_spacing, out_distance, zero fill.
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   m_axis_tlast,
  output int                     mismatch_count_o,
  output int                     entries_due_o
);

  localparam int ENTRY_BITS = 2 * POS_W + FEAT_W + SPC_W + DIST_W;
  localparam int PRINT_CAP  = 40;

  typedef struct packed {
    logic [SPC_W-1:0]  min_spacing;
    logic [POS_W-1:0]  pos_y;
    logic [POS_W-1:0]  pos_x;
    logic [FEAT_W-1:0] residual;
    logic [FEAT_W-1:0] slope;
    logic [FEAT_W-1:0] pattern;
  } record_word_t;

  typedef struct packed {
    logic [OUT_TDATA_W-ENTRY_BITS-1:0] zero_fill;
    logic [DIST_W-1:0]                 distance;
    logic [SPC_W-1:0]                  min_spacing;
    logic [FEAT_W-1:0]                 residual;
    logic [POS_W-1:0]                  pos_y;
    logic [POS_W-1:0]                  pos_x;
  } entry_word_t;

  typedef struct {
    entry_word_t word;
    logic        last;
  } due_entry_t;

  logic signed [FEAT_W-1:0] query_pattern = '0;
  logic signed [FEAT_W-1:0] query_slope   = '0;
  logic signed [FEAT_W-1:0] query_residual = '0;
  logic [K_W-1:0]           k_count = K_RESET;

  entry_word_t kept_slot [SLOTS];
  int          fill_level = 0;
  due_entry_t  due_q [$];
  int          mismatches = 0;

  function automatic logic [DIST_W-1:0] feature_distance(input record_word_t rec);
    longint dp, ds, dr;
    logic [DIST_W-1:0] sum;
    dp = longint'($signed(rec.pattern)) - longint'(query_pattern);
    ds = longint'($signed(rec.slope)) - longint'(query_slope);
    dr = longint'($signed(rec.residual)) - longint'(query_residual);
    sum = DIST_W'(dp * dp + ds * ds + dr * dr);
    return sum;
  endfunction

  // A k of zero keeps one record and anything above the slot count keeps them all.
  function automatic int keep_limit();
    int k;
    k = int'(k_count);
    if (k == 0) k = 1;
    if (k > SLOTS) k = SLOTS;
    return k;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] seen,
                               input logic [63:0] due);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, seen, due);
  endtask

  task automatic absorb_record(input logic [IN_TDATA_W-1:0] data, input logic eos);
    record_word_t rec;
    entry_word_t  entry;
    due_entry_t   due;
    int           worst;
    int           i;
    rec = data;
    entry = '0;
    entry.pos_x = rec.pos_x;
    entry.pos_y = rec.pos_y;
    entry.residual = rec.residual;
    entry.min_spacing = rec.min_spacing;
    entry.distance = feature_distance(rec);
    if (fill_level < keep_limit()) begin
      kept_slot[fill_level] = entry;
      fill_level++;
    end else if (fill_level > 0) begin
      // Scan every filled slot, even past a lowered k; the earliest wins a tie.
      worst = 0;
      for (i = 1; i < fill_level; i++)
        if (kept_slot[i].distance > kept_slot[worst].distance) worst = i;
      if (kept_slot[worst].distance > entry.distance) kept_slot[worst] = entry;
    end
    if (eos) begin
      for (i = 0; i < fill_level; i++) begin
        due.word = kept_slot[i];
        due.last = (i == fill_level - 1);
        due_q.push_back(due);
      end
      fill_level = 0;
    end
  endtask

  task automatic check_entry();
    entry_word_t got;
    due_entry_t  want;
    got = m_axis_tdata;
    if (due_q.size() == 0) begin
      flag_mismatch("unexpected result, out_x", got.pos_x, '0);
    end else begin
      want = due_q.pop_front();
      if (got.pos_x !== want.word.pos_x) flag_mismatch("out_x", got.pos_x, want.word.pos_x);
      if (got.pos_y !== want.word.pos_y) flag_mismatch("out_y", got.pos_y, want.word.pos_y);
      if (got.residual !== want.word.residual)
        flag_mismatch("out_residual", got.residual, want.word.residual);
      if (got.min_spacing !== want.word.min_spacing)
        flag_mismatch("out_min_spacing", got.min_spacing, want.word.min_spacing);
      if (got.distance !== want.word.distance)
        flag_mismatch("out_distance", got.distance, want.word.distance);
      if (got.zero_fill !== '0) flag_mismatch("tdata zero fill", got.zero_fill, '0);
      if (m_axis_tlast !== want.last) flag_mismatch("last_of_run", m_axis_tlast, want.last);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_pattern = '0;
      query_slope = '0;
      query_residual = '0;
      k_count = K_RESET;
      fill_level = 0;
      due_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_addr_i))
          REG_QUERY_PATTERN:  query_pattern = cfg_wdata_i[FEAT_W-1:0];
          REG_QUERY_SLOPE:    query_slope = cfg_wdata_i[FEAT_W-1:0];
          REG_QUERY_RESIDUAL: query_residual = cfg_wdata_i[FEAT_W-1:0];
          REG_K_COUNT:        k_count = cfg_wdata_i[K_W-1:0];
          default: ;
        endcase
      end
      // Results belong to sets closed earlier, so they are checked before a new record.
      if (m_axis_tvalid && m_axis_tready) check_entry();
      if (s_axis_tvalid && s_axis_tready) absorb_record(s_axis_tdata, s_axis_tlast);
    end
    entries_due_o <= due_q.size();
    mismatch_count_o <= mismatches;
  end

endmodule

// ----- verif/k_nearest_feature_select_core_test.sv -----
`timescale 1ns / 1ps

module k_nearest_feature_select_core_test;

  import knfs_pkg::*;

  // Enough random records for the main part of the run.
  localparam int RANDOM_ITEMS   = 200;
  // Covers the longest a record can take, a full scan of the kept set included,
  // and so any work still running after the last result of a phase has come out.
  localparam int DRAIN_CYCLES   = 48;
  // The long receiver hold-off that backs the block up into its input.
  localparam int HOLD_CYCLES    = 600;
  // Cycles without any transaction before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 4000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // From bit 0 up: point_pattern, mean_slope, residual, pos_x, pos_y, min_spacing.
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // From bit 0 up: out_x, out_y, out_residual, out_min_spacing, out_distance, zero fill.
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  int mismatch_count;
  int entries_due;

  // Idling switches, changed per phase so that some phases run without gaps.
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int hold_seq = 0;
  int hold_seen = 0;
  int rx_wait = 0;
  int quiet_cycles = 0;

  // The query currently programmed, so that features can be drawn close to it.
  logic [FEAT_W-1:0] qp_now = '0;
  logic [FEAT_W-1:0] qs_now = '0;
  logic [FEAT_W-1:0] qr_now = '0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  k_nearest_feature_select_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  knfs_kept_set_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tlast     (s_axis_tlast),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tlast     (m_axis_tlast),
    .mismatch_count_o (mismatch_count),
    .entries_due_o    (entries_due)
  );

  // Gap lengths: mostly none or a few cycles, now and then a long one.
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 10) return 0;
    if (roll < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // A feature value: fully random, near the query, at an extreme, or exactly
  // one step of 1.0 away from the query so that equal distances show up.
  function automatic logic [FEAT_W-1:0] pick_feature(input logic [FEAT_W-1:0] centre);
    logic [FEAT_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = FEAT_W'($urandom);
      4, 5, 6:    v = centre + FEAT_W'($urandom_range(0, 64)) - FEAT_W'(32);
      7:          v = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      default:    v = centre + ($urandom_range(0, 1) ? 16'h0100 : 16'hFF00);
    endcase
    return v;
  endfunction

  // k as written to the register, including zero and values above the slot count.
  // The bits above the k field are random and must be ignored by the block.
  function automatic logic [CFG_DATA_W-1:0] pick_k();
    logic [CFG_DATA_W-1:0] v;
    v = CFG_DATA_W'($urandom);
    case ($urandom_range(0, 7))
      0:       v[K_W-1:0] = '0;
      1:       v[K_W-1:0] = K_W'(1);
      2:       v[K_W-1:0] = K_W'(SLOTS);
      3:       v[K_W-1:0] = K_W'($urandom_range(SLOTS + 1, 31));
      default: v[K_W-1:0] = K_W'($urandom_range(2, SLOTS - 1));
    endcase
    return v;
  endfunction

  function automatic logic [FEAT_W-1:0] pick_query();
    logic [FEAT_W-1:0] v;
    case ($urandom_range(0, 8))
      6:       v = 16'h8000;
      7:       v = 16'h7FFF;
      8:       v = '0;
      default: v = FEAT_W'($urandom);
    endcase
    return v;
  endfunction

  // One register write per clock; the write enable is raised once and the
  // caller lowers it after the last write of a group.
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
  endtask

  // Writes the registers selected in the mask, in register order.
  task automatic configure(input logic [FEAT_W-1:0] qp, input logic [FEAT_W-1:0] qs,
                           input logic [FEAT_W-1:0] qr, input logic [CFG_DATA_W-1:0] kv,
                           input logic [3:0] mask);
    if (mask[0]) begin
      write_reg(REG_QUERY_PATTERN, qp);
      qp_now = qp;
    end
    if (mask[1]) begin
      write_reg(REG_QUERY_SLOPE, qs);
      qs_now = qs;
    end
    if (mask[2]) begin
      write_reg(REG_QUERY_RESIDUAL, qr);
      qr_now = qr;
    end
    if (mask[3]) write_reg(REG_K_COUNT, kv);
    cfg_we_i <= 1'b0;
  endtask

  // Offers one record and returns at the clock edge of its transaction. The
  // valid stays high into the next record when no gap is drawn.
  task automatic send_record(input logic [FEAT_W-1:0] pat, input logic [FEAT_W-1:0] slp,
                             input logic [FEAT_W-1:0] res, input logic [POS_W-1:0] px,
                             input logic [POS_W-1:0] py, input logic [SPC_W-1:0] spc,
                             input logic eos);
    int gap;
    gap = tx_idle_on ? idle_len() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {spc, py, px, res, slp, pat};
    s_axis_tlast <= eos;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send_random(input logic eos);
    send_record(pick_feature(qp_now), pick_feature(qs_now), pick_feature(qr_now),
                $urandom, $urandom, SPC_W'($urandom), eos);
  endtask

  // Waits until every expected result has come out, then lets any record that
  // produces no result finish inside the block before the next register write.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (entries_due != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Receiver: random stalls when enabled, plus one long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      rx_wait = HOLD_CYCLES;
    end
    if (rx_wait > 0) begin
      m_axis_tready <= 1'b0;
      rx_wait--;
    end else if (rx_idle_on && $urandom_range(0, 3) == 0 && (rx_wait = idle_len()) > 0) begin
      m_axis_tready <= 1'b0;
      rx_wait--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog: a long stretch with no transaction on any port means a hang.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int i;
    int s;
    int j;
    int nsets;
    int len;
    int phase;
    int random_items;
    bit open_end;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, with the reset query of zero and k of eight.
    // Feature, position and spacing extremes; fewer records than k, so only
    // the three present come out.
    send_record(16'h8000, 16'h8000, 16'h8000, 32'h8000_0000, 32'h7FFF_FFFF, 24'hFF_FFFF, 1'b0);
    send_record(16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h7FFF_FFFF, 32'h8000_0000, 24'h00_0000, 1'b0);
    send_record(16'h0000, 16'h0000, 16'h0000, 32'h0000_0000, 32'hFFFF_FFFF, 24'h00_0001, 1'b1);

    // Eight records at the same distance fill the set. A closer one then takes
    // the earliest of the tied slots, and a record at exactly the largest kept
    // distance is not taken, since replacement needs a strictly larger one.
    for (i = 0; i < 10; i++)
      send_record((i == 8) ? 16'h0000 : ((i % 2) ? 16'h0100 : 16'hFF00), 16'h0000,
                  16'h0000, i, ~i, SPC_W'(i * 1000), i == 9);

    // A set of a single record.
    send_random(1'b1);
    settle();

    // Query at the top of the range and a k of zero, which keeps one record.
    // The largest possible distance goes in first and is then replaced.
    configure(16'h7FFF, 16'h7FFF, 16'h7FFF, '0, 4'b1111);
    send_record(16'h8000, 16'h8000, 16'h8000, $urandom, $urandom, SPC_W'($urandom), 1'b0);
    send_record(16'h7FFF, 16'h7FFF, 16'h7FFF, $urandom, $urandom, SPC_W'($urandom), 1'b0);
    send_record(16'h0000, 16'h0000, 16'h0000, $urandom, $urandom, SPC_W'($urandom), 1'b1);
    settle();

    // k lowered in the middle of a set: the four kept records stay and all of
    // them are scanned for replacement and sent out.
    configure(16'h8000, 16'h8000, 16'h8000, CFG_DATA_W'(SLOTS), 4'b1111);
    for (i = 0; i < 4; i++) send_random(1'b0);
    settle();
    configure('0, '0, '0, CFG_DATA_W'(2), 4'b1000);
    for (i = 0; i < 3; i++) send_random(i == 2);
    settle();

    // Random part. Each phase draws a new configuration, then a few sets of
    // random length; now and then the phase stops in the middle of a set so
    // that the next configuration lands on a partly filled set.
    random_items = 0;
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      configure(pick_query(), pick_query(), pick_query(), pick_k(), 4'($urandom_range(1, 15)));
      nsets = $urandom_range(1, 4);
      open_end = ($urandom_range(0, 4) == 0);
      if (phase == 1) begin
        // Hold the receiver off while short sets keep coming, so that the
        // block backs up and stops taking records.
        hold_seq <= hold_seq + 1;
        tx_idle_on = 1'b0;
        nsets = 6;
        open_end = 1'b0;
      end
      for (s = 0; s < nsets; s++) begin
        case ($urandom_range(0, 9))
          0:       len = 1;
          7, 8:    len = $urandom_range(13, 24);
          9:       len = $urandom_range(25, 40);
          default: len = $urandom_range(2, 12);
        endcase
        if (phase == 1) len = $urandom_range(1, 6);
        for (j = 0; j < len; j++) begin
          send_random((j == len - 1) && !(s == nsets - 1 && open_end));
          random_items++;
        end
      end
      settle();
      phase++;
    end

    if (mismatch_count == 0 && entries_due == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/knfs_pkg.sv
src/knfs_dist.sv
src/knfs_slot_ram.sv
src/k_nearest_feature_select_core.sv
src/knfs_checker.sv
verif/knfs_kept_set_checker.sv
verif/k_nearest_feature_select_core_test.sv
